[sv/etl_pkg.sv]
// Shared types and constants for the expression token lexer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package etl_pkg;

   // Field widths and defaults
   localparam int CHAR_BITS           = 8;
   localparam int VALUE_BITS          = 32;
   localparam int LENGTH_BITS         = 12;
   localparam int LINE_BITS_DEFAULT   = 20;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int RESULT_DEPTH        = 4;

   localparam logic [LENGTH_BITS-1:0] MAX_IDENT_RESET = 12'd511;

   // Character class picked by the front end
   typedef enum logic [3:0] {
      CLS_SPACE,
      CLS_END,
      CLS_PLUS,
      CLS_MINUS,
      CLS_STAR,
      CLS_SLASH,
      CLS_SEMI,
      CLS_EQUAL,
      CLS_BANG,
      CLS_LESS,
      CLS_GREATER,
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_OTHER
   } char_class_type;

   // One classified source byte
   typedef struct packed {
      char_class_type        cls;
      logic [CHAR_BITS-1:0]  code;
   } class_item_type;

   typedef enum logic [4:0] {
      TK_END     = 5'd0,
      TK_PLUS    = 5'd1,
      TK_MINUS   = 5'd2,
      TK_STAR    = 5'd3,
      TK_SLASH   = 5'd4,
      TK_SEMI    = 5'd5,
      TK_ASSIGN  = 5'd6,
      TK_EQ      = 5'd7,
      TK_NE      = 5'd8,
      TK_LT      = 5'd9,
      TK_GT      = 5'd10,
      TK_LE      = 5'd11,
      TK_GE      = 5'd12,
      TK_INTLIT  = 5'd13,
      TK_IDENT   = 5'd14,
      TK_PRINT   = 5'd15,
      TK_INT     = 5'd16,
      TK_IDCHAR  = 5'd17,
      TK_ERROR   = 5'd18
   } token_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNKNOWN   = 2'd1,
      ERR_BANG      = 2'd2,
      ERR_TOO_LONG  = 2'd3
   } error_code_type;

   // One result item, minus the line number
   typedef struct packed {
      token_kind_type          kind;
      logic [VALUE_BITS-1:0]   value;
      logic                    overflow;
      logic [LENGTH_BITS-1:0]  length;
      error_code_type          error;
      logic                    last;
   } result_type;

endpackage

`default_nettype wire

[sv/etl_front.sv]
// Front end of the lexer: classifies each accepted byte and counts lines.
// Depends on etl_pkg.
`default_nettype none

module etl_front import etl_pkg::*; #(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [CHAR_BITS-1:0]  char_code,
   output class_item_type             item,
   output logic [LINE_BITS-1:0]       line
);

   localparam logic [CHAR_BITS-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_LF      = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_FF      = 8'h0C;
   localparam logic [CHAR_BITS-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_BANG    = 8'h21;
   localparam logic [CHAR_BITS-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CHAR_BITS-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_SEMI    = 8'h3B;
   localparam logic [CHAR_BITS-1:0] CH_LESS    = 8'h3C;
   localparam logic [CHAR_BITS-1:0] CH_EQUAL   = 8'h3D;
   localparam logic [CHAR_BITS-1:0] CH_GREATER = 8'h3E;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CH_UNDER   = 8'h5F;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;

   localparam logic [LINE_BITS-1:0] LINE_FIRST = LINE_BITS'(1);

   logic [LINE_BITS-1:0] line_ff;
   logic [LINE_BITS-1:0] line_in;
   logic [LINE_BITS-1:0] line_bump;

   // Classify the byte
   always_comb begin
      item.code = char_code;
      case (char_code) inside
         CH_NUL:                                     item.cls = CLS_END;
         CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE:      item.cls = CLS_SPACE;
         CH_PLUS:                                    item.cls = CLS_PLUS;
         CH_MINUS:                                   item.cls = CLS_MINUS;
         CH_STAR:                                    item.cls = CLS_STAR;
         CH_SLASH:                                   item.cls = CLS_SLASH;
         CH_SEMI:                                    item.cls = CLS_SEMI;
         CH_EQUAL:                                   item.cls = CLS_EQUAL;
         CH_BANG:                                    item.cls = CLS_BANG;
         CH_LESS:                                    item.cls = CLS_LESS;
         CH_GREATER:                                 item.cls = CLS_GREATER;
         [CH_DIGIT_0:CH_DIGIT_9]:                    item.cls = CLS_DIGIT;
         [CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z], CH_UNDER:
                                                     item.cls = CLS_ALPHA;
         default:                                    item.cls = CLS_OTHER;
      endcase
   end

   // Count newlines, saturating; restart the count after the end byte
   always_comb begin
      line_bump = line_ff;
      if (char_code == CH_LF && !(&line_ff)) begin
         line_bump = line_ff + 1'b1;
      end
      line_in = line_ff;
      if (accept) begin
         line_in = (char_code == CH_NUL) ? LINE_FIRST : line_bump;
      end
   end

   assign line = line_bump;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= LINE_FIRST;
      end else begin
         line_ff <= line_in;
      end
   end

endmodule

`default_nettype wire

[sv/etl_fifo.sv]
// Small register queue between the lexer front end and back end.
// Depends on etl_pkg for the default depth.
`default_nettype none

module etl_fifo import etl_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic                   full,
   input  wire logic              pop,
   output logic [WIDTH-1:0]       rdata,
   output logic                   empty
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam logic [PTR_BITS:0] COUNT_FULL = (PTR_BITS + 1)'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS:0]   count_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [PTR_BITS:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == COUNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS + 1)'(do_push) - (PTR_BITS + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

[sv/etl_back.sv]
// Back end of the lexer: scanner state machine, limit register, result queue.
// Depends on etl_pkg.
`default_nettype none

module etl_back import etl_pkg::*; #(
   parameter int LINE_BITS = LINE_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_empty,
   output logic                         in_pop,
   input  wire class_item_type          in_item,
   input  wire logic [LINE_BITS-1:0]    in_line,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [LENGTH_BITS-1:0]  csr_max_ident_chars,
   input  wire logic                    rsp_pop,
   output logic                         rsp_empty,
   output result_type                   rsp_head,
   output logic [LINE_BITS-1:0]         rsp_line
);

   typedef enum logic [2:0] {
      MODE_START,
      MODE_EQ,
      MODE_BANG,
      MODE_LT,
      MODE_GT,
      MODE_INT,
      MODE_IDENT,
      MODE_HOLD
   } mode_type;

   // Keyword match progress: p, pr, pri, prin, print, i, in, int
   localparam logic [3:0] KW_NONE  = 4'd0;
   localparam logic [3:0] KW_P     = 4'd1;
   localparam logic [3:0] KW_PR    = 4'd2;
   localparam logic [3:0] KW_PRI   = 4'd3;
   localparam logic [3:0] KW_PRIN  = 4'd4;
   localparam logic [3:0] KW_PRINT = 4'd5;
   localparam logic [3:0] KW_I     = 4'd6;
   localparam logic [3:0] KW_IN    = 4'd7;
   localparam logic [3:0] KW_INT   = 4'd8;

   localparam logic [CHAR_BITS-1:0] CH_I = 8'h69;
   localparam logic [CHAR_BITS-1:0] CH_N = 8'h6E;
   localparam logic [CHAR_BITS-1:0] CH_P = 8'h70;
   localparam logic [CHAR_BITS-1:0] CH_R = 8'h72;
   localparam logic [CHAR_BITS-1:0] CH_T = 8'h74;

   localparam int OUT_PTR_BITS = $clog2(RESULT_DEPTH);
   localparam logic [OUT_PTR_BITS:0] OUT_ROOM = (OUT_PTR_BITS + 1)'(RESULT_DEPTH - 2);
   localparam logic [LENGTH_BITS-1:0] LENGTH_ONE = LENGTH_BITS'(1);

   function automatic logic [CHAR_BITS-1:0] kw_next(logic [3:0] progress);
      case (progress)
         KW_P:    return CH_R;
         KW_PR:   return CH_I;
         KW_PRI:  return CH_N;
         KW_PRIN: return CH_T;
         KW_I:    return CH_N;
         KW_IN:   return CH_T;
         default: return '0;
      endcase
   endfunction

   function automatic result_type make_result(token_kind_type kind,
                                              logic [VALUE_BITS-1:0] value,
                                              logic overflow,
                                              logic [LENGTH_BITS-1:0] length,
                                              error_code_type error);
      result_type r;
      r.kind     = kind;
      r.value    = value;
      r.overflow = overflow;
      r.length   = length;
      r.error    = error;
      r.last     = 1'b0;
      return r;
   endfunction

   // Scanner state
   mode_type                 mode_ff, mode_in;
   logic [VALUE_BITS-1:0]    acc_ff, acc_in;
   logic                     ovf_ff, ovf_in;
   logic [LENGTH_BITS-1:0]   count_ff, count_in;
   logic [3:0]               kw_ff, kw_in;
   logic [LENGTH_BITS-1:0]   max_ff;

   // New-token outcome for the current byte
   logic                     beg_emit;
   result_type               beg_res;
   mode_type                 beg_mode;
   logic [VALUE_BITS-1:0]    beg_acc;
   logic [LENGTH_BITS-1:0]   beg_count;
   logic [3:0]               beg_kw;

   // Results of the current byte
   logic                     run_begin;
   logic [1:0]               n_res;
   result_type               res0;
   result_type               res1;
   logic [VALUE_BITS+3:0]    acc_next;
   logic [LENGTH_BITS-1:0]   count_up;
   logic                     is_word;
   logic                     take;

   // Result queue
   result_type               res_mem_ff  [RESULT_DEPTH];
   logic [LINE_BITS-1:0]     line_mem_ff [RESULT_DEPTH];
   logic [OUT_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [OUT_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OUT_PTR_BITS:0]    out_count_ff, out_count_in;
   logic [1:0]               n_written;
   logic                     do_out_pop;

   assign csr_ready  = 1'b1;
   assign take       = !in_empty && (out_count_ff <= OUT_ROOM);
   assign in_pop     = take;
   assign is_word    = (in_item.cls == CLS_DIGIT) || (in_item.cls == CLS_ALPHA);
   assign count_up   = count_ff + 1'b1;
   assign acc_next   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                       + (VALUE_BITS + 4)'(in_item.code[3:0]);

   // Start a new token from this byte
   always_comb begin
      beg_emit  = 1'b0;
      beg_res   = make_result(TK_END, '0, 1'b0, '0, ERR_NONE);
      beg_mode  = MODE_START;
      beg_acc   = '0;
      beg_count = '0;
      beg_kw    = KW_NONE;
      case (in_item.cls)
         CLS_SPACE: begin
         end
         CLS_END: begin
            beg_emit = 1'b1;
         end
         CLS_PLUS: begin
            beg_emit = 1'b1;
            beg_res  = make_result(TK_PLUS, '0, 1'b0, '0, ERR_NONE);
         end
         CLS_MINUS: begin
            beg_emit = 1'b1;
            beg_res  = make_result(TK_MINUS, '0, 1'b0, '0, ERR_NONE);
         end
         CLS_STAR: begin
            beg_emit = 1'b1;
            beg_res  = make_result(TK_STAR, '0, 1'b0, '0, ERR_NONE);
         end
         CLS_SLASH: begin
            beg_emit = 1'b1;
            beg_res  = make_result(TK_SLASH, '0, 1'b0, '0, ERR_NONE);
         end
         CLS_SEMI: begin
            beg_emit = 1'b1;
            beg_res  = make_result(TK_SEMI, '0, 1'b0, '0, ERR_NONE);
         end
         CLS_EQUAL:   beg_mode = MODE_EQ;
         CLS_BANG:    beg_mode = MODE_BANG;
         CLS_LESS:    beg_mode = MODE_LT;
         CLS_GREATER: beg_mode = MODE_GT;
         CLS_DIGIT: begin
            beg_mode = MODE_INT;
            beg_acc  = VALUE_BITS'(in_item.code[3:0]);
         end
         CLS_ALPHA: begin
            beg_emit = 1'b1;
            if (max_ff == '0) begin
               beg_mode = MODE_HOLD;
               beg_res  = make_result(TK_ERROR, '0, 1'b0, '0, ERR_TOO_LONG);
            end else begin
               beg_mode  = MODE_IDENT;
               beg_count = LENGTH_ONE;
               beg_kw    = (in_item.code == CH_P) ? KW_P :
                           (in_item.code == CH_I) ? KW_I : KW_NONE;
               beg_res   = make_result(TK_IDCHAR, VALUE_BITS'(in_item.code), 1'b0,
                                       LENGTH_ONE, ERR_NONE);
            end
         end
         default: begin
            beg_emit = 1'b1;
            beg_mode = MODE_HOLD;
            beg_res  = make_result(TK_ERROR, '0, 1'b0, '0, ERR_UNKNOWN);
         end
      endcase
   end

   // Close the pending token, then start a new one where the byte allows
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      count_in  = count_ff;
      kw_in     = kw_ff;
      run_begin = 1'b0;
      n_res     = 2'd0;
      res0      = make_result(TK_END, '0, 1'b0, '0, ERR_NONE);
      res1      = make_result(TK_END, '0, 1'b0, '0, ERR_NONE);
      case (mode_ff)
         MODE_EQ: begin
            n_res = 2'd1;
            if (in_item.cls == CLS_EQUAL) begin
               res0    = make_result(TK_EQ, '0, 1'b0, '0, ERR_NONE);
               mode_in = MODE_START;
            end else begin
               res0      = make_result(TK_ASSIGN, '0, 1'b0, '0, ERR_NONE);
               run_begin = 1'b1;
            end
         end
         MODE_LT: begin
            n_res = 2'd1;
            if (in_item.cls == CLS_EQUAL) begin
               res0    = make_result(TK_LE, '0, 1'b0, '0, ERR_NONE);
               mode_in = MODE_START;
            end else begin
               res0      = make_result(TK_LT, '0, 1'b0, '0, ERR_NONE);
               run_begin = 1'b1;
            end
         end
         MODE_GT: begin
            n_res = 2'd1;
            if (in_item.cls == CLS_EQUAL) begin
               res0    = make_result(TK_GE, '0, 1'b0, '0, ERR_NONE);
               mode_in = MODE_START;
            end else begin
               res0      = make_result(TK_GT, '0, 1'b0, '0, ERR_NONE);
               run_begin = 1'b1;
            end
         end
         MODE_BANG: begin
            n_res = 2'd1;
            if (in_item.cls == CLS_EQUAL) begin
               res0    = make_result(TK_NE, '0, 1'b0, '0, ERR_NONE);
               mode_in = MODE_START;
            end else begin
               res0    = make_result(TK_ERROR, '0, 1'b0, '0, ERR_BANG);
               mode_in = MODE_HOLD;
               if (in_item.cls == CLS_END) begin
                  // Error, then end of stream; clear the scanner
                  n_res    = 2'd2;
                  mode_in  = MODE_START;
                  acc_in   = '0;
                  ovf_in   = 1'b0;
                  count_in = '0;
                  kw_in    = KW_NONE;
               end
            end
         end
         MODE_INT: begin
            if (in_item.cls == CLS_DIGIT) begin
               acc_in = acc_next[VALUE_BITS-1:0];
               ovf_in = ovf_ff || (acc_next[VALUE_BITS+3:VALUE_BITS] != '0);
            end else begin
               n_res     = 2'd1;
               res0      = make_result(TK_INTLIT, acc_ff, ovf_ff, '0, ERR_NONE);
               run_begin = 1'b1;
            end
         end
         MODE_IDENT: begin
            n_res = 2'd1;
            if (is_word) begin
               if (count_ff >= max_ff) begin
                  res0    = make_result(TK_ERROR, '0, 1'b0, '0, ERR_TOO_LONG);
                  mode_in = MODE_HOLD;
               end else begin
                  count_in = count_up;
                  kw_in    = (in_item.code == kw_next(kw_ff)) ? kw_ff + 1'b1 : KW_NONE;
                  res0     = make_result(TK_IDCHAR, VALUE_BITS'(in_item.code), 1'b0,
                                         count_up, ERR_NONE);
               end
            end else begin
               res0 = make_result((kw_ff == KW_PRINT) ? TK_PRINT :
                                  (kw_ff == KW_INT) ? TK_INT : TK_IDENT,
                                  '0, 1'b0, count_ff, ERR_NONE);
               run_begin = 1'b1;
            end
         end
         MODE_HOLD: begin
            if (in_item.cls == CLS_END) begin
               n_res    = 2'd1;
               mode_in  = MODE_START;
               acc_in   = '0;
               ovf_in   = 1'b0;
               count_in = '0;
               kw_in    = KW_NONE;
            end
         end
         default: begin
            run_begin = 1'b1;
         end
      endcase

      if (run_begin) begin
         mode_in  = beg_mode;
         acc_in   = beg_acc;
         ovf_in   = 1'b0;
         count_in = beg_count;
         kw_in    = beg_kw;
         if (beg_emit) begin
            if (n_res == 2'd0) begin
               res0 = beg_res;
            end else begin
               res1 = beg_res;
            end
            n_res = n_res + 1'b1;
         end
      end

      // Mark the final result of this byte
      res0.last = (n_res == 2'd1);
      res1.last = 1'b1;
   end

   // Hold scanner state and the limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_START;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         count_ff <= '0;
         kw_ff    <= KW_NONE;
         max_ff   <= MAX_IDENT_RESET;
      end else begin
         if (take) begin
            mode_ff  <= mode_in;
            acc_ff   <= acc_in;
            ovf_ff   <= ovf_in;
            count_ff <= count_in;
            kw_ff    <= kw_in;
         end
         if (csr_valid && csr_ready) begin
            max_ff <= csr_max_ident_chars;
         end
      end
   end

   // Result queue bookkeeping
   assign do_out_pop  = rsp_pop && !rsp_empty;
   assign n_written   = take ? n_res : 2'd0;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in    = wr_ptr_ff + OUT_PTR_BITS'(n_written);
      rd_ptr_in    = do_out_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      out_count_in = out_count_ff + (OUT_PTR_BITS + 1)'(n_written)
                     - (OUT_PTR_BITS + 1)'(do_out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         out_count_ff <= out_count_in;
      end
   end

   // Write up to two results per byte
   always_ff @(posedge clock) begin
      if (n_written != 2'd0) begin
         res_mem_ff[wr_ptr_ff]  <= res0;
         line_mem_ff[wr_ptr_ff] <= in_line;
      end
      if (n_written == 2'd2) begin
         res_mem_ff[wr_ptr_next]  <= res1;
         line_mem_ff[wr_ptr_next] <= in_line;
      end
   end

   assign rsp_empty = (out_count_ff == '0);
   assign rsp_head  = res_mem_ff[rd_ptr_ff];
   assign rsp_line  = line_mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[sv/expression_token_lexer_unit.sv]
// Expression token lexer: one source byte per cycle in while req_full is low, tokens out as a queue.
// An accepted byte is registered in the byte queue, then scanned into the result queue.
// Throughput: one byte per cycle, set by the scanner stage, while the queues have room; the result
// queue drains one result per cycle, so a byte that closes one token and opens another leaves two results.
// Reset (synchronous): queues empty, scanner at start, line number 1, identifier limit 511.
`default_nettype none

module expression_token_lexer_unit import etl_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire logic [CHAR_BITS-1:0]    req_char_code,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [LENGTH_BITS-1:0]  csr_max_ident_chars,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output logic [4:0]                   rsp_token_kind,
   output logic [VALUE_BITS-1:0]        rsp_token_value,
   output logic                         rsp_literal_overflow,
   output logic [LENGTH_BITS-1:0]       rsp_ident_length,
   output logic [1:0]                   rsp_error_code,
   output logic [LINE_BITS-1:0]         rsp_line_number,
   output logic                         rsp_last_of_run
);

   localparam int ITEM_BITS = $bits(class_item_type);
   localparam int MID_WIDTH = ITEM_BITS + LINE_BITS;

   logic                  req_take;
   class_item_type        front_item;
   logic [LINE_BITS-1:0]  front_line;
   logic [MID_WIDTH-1:0]  mid_wdata;
   logic [MID_WIDTH-1:0]  mid_rdata;
   logic                  mid_full;
   logic                  mid_empty;
   logic                  mid_pop;
   class_item_type        mid_item;
   logic [LINE_BITS-1:0]  mid_line;
   result_type            head;

   assign req_take  = req_push && !req_full;
   assign req_full  = mid_full;
   assign mid_wdata = {front_item, front_line};
   assign mid_item  = class_item_type'(mid_rdata[MID_WIDTH-1:LINE_BITS]);
   assign mid_line  = mid_rdata[LINE_BITS-1:0];

   etl_front #(
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_take),
      .char_code (req_char_code),
      .item      (front_item),
      .line      (front_line)
   );

   etl_fifo #(
      .WIDTH (MID_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_take),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   etl_back #(
      .LINE_BITS (LINE_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .in_empty            (mid_empty),
      .in_pop              (mid_pop),
      .in_item             (mid_item),
      .in_line             (mid_line),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_ident_chars (csr_max_ident_chars),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_head            (head),
      .rsp_line            (rsp_line_number)
   );

   // Drive result fields from the queue head
   assign rsp_token_kind       = head.kind;
   assign rsp_token_value      = head.value;
   assign rsp_literal_overflow = head.overflow;
   assign rsp_ident_length     = head.length;
   assign rsp_error_code       = head.error;
   assign rsp_last_of_run      = head.last;

`ifndef SYNTHESIS
   // Both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not empty after reset");

   // Error code is set exactly on error tokens
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_token_kind == TK_ERROR) == (rsp_error_code != ERR_NONE)))
      else $error("error code does not match token kind");

   // The end token always closes the run of its byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_token_kind == TK_END) |-> rsp_last_of_run)
      else $error("end token not marked last of run");

   // Line numbers start at one and never reach zero
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_line_number != '0))
      else $error("line number is zero");
`endif

endmodule

`default_nettype wire
